// ----- design/dcr_pkg.sv -----
// Package for the disc collision response pipeline.
// Holds widths, reset values and the shared velocity types.
// No dependencies; used by dcr_div and disc_collision_response.
package dcr_pkg;

  // Fixed point format of positions and velocities
  localparam int FRAC_BITS  = 16;
  localparam int VEL_W      = 32;
  localparam int RAD_W      = 31;
  localparam int MASS_W     = 16;

  // Restitution register, unsigned Q1.16
  localparam int REST_W     = 17;
  localparam int REST_FRAC  = 16;
  localparam logic [REST_W-1:0] REST_RESET = REST_W'(1 << REST_FRAC);

  // Geometry widths
  localparam int DIFF_W     = VEL_W + 1;            // coordinate differences
  localparam int SQ_W       = 2 * DIFF_W;           // squares and products
  localparam int D2_W       = SQ_W + 1;             // squared distance
  localparam int P_W        = SQ_W + 1;             // signed closing product
  localparam int RS_W       = RAD_W + 1;            // radius sum
  localparam int RSQ_W      = 2 * RS_W;
  localparam int AXIS_W     = VEL_W;                // |da| on a colliding pair
  localparam int PL_W       = 32;                   // low slice of P
  localparam int PH_W       = P_W - 2 - PL_W;       // high slice of P (P < 2^65)
  localparam int PP_W       = PL_W + PH_W + AXIS_W; // P * |da|
  localparam int NM_W       = MASS_W + REST_W + 1;  // mass * (1 + e)

  // Shared divider geometry
  localparam int DIV_QUO_W  = 35;
  localparam int DIV_DEN_W  = 66;
  localparam int DIV_NUM_W  = DIV_DEN_W + DIV_QUO_W;
  localparam int DIV_LAT    = DIV_QUO_W + 1;

  // Response scaling
  localparam int FACT_W     = FRAC_BITS + 2;
  localparam int PROD_W     = DIV_QUO_W + FACT_W;
  localparam int TRIM_W     = PROD_W + 1 - FRAC_BITS;
  localparam int ACC_W      = TRIM_W + 2;

  typedef struct packed {
    logic signed [VEL_W-1:0] vx1;
    logic signed [VEL_W-1:0] vy1;
    logic signed [VEL_W-1:0] vx2;
    logic signed [VEL_W-1:0] vy2;
  } vel_t;

  typedef struct packed {
    logic hit;
    logic negx;
    logic negy;
    vel_t vel;
  } side_t;

endpackage

// ----- design/disc_collision_response.sv -----
// Disc pair collision response, pipelined; one request per clock cycle.
// done_o is registered; each pair passes stages 1 to 5, the quotient pipelines,
// the scale and round registers and the output register; throughput one pair per cycle.
// busy is always low and results are never held. Reset clears all valid
// bits and loads restitution with 65536. Depends on dcr_pkg and dcr_div.
module disc_collision_response (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [dcr_pkg::VEL_W-1:0]    first_x_i,
  input  logic signed [dcr_pkg::VEL_W-1:0]    first_y_i,
  input  logic signed [dcr_pkg::VEL_W-1:0]    first_vel_x_i,
  input  logic signed [dcr_pkg::VEL_W-1:0]    first_vel_y_i,
  input  logic        [dcr_pkg::RAD_W-1:0]    first_radius_i,
  input  logic        [dcr_pkg::MASS_W-1:0]   first_mass_i,
  input  logic signed [dcr_pkg::VEL_W-1:0]    second_x_i,
  input  logic signed [dcr_pkg::VEL_W-1:0]    second_y_i,
  input  logic signed [dcr_pkg::VEL_W-1:0]    second_vel_x_i,
  input  logic signed [dcr_pkg::VEL_W-1:0]    second_vel_y_i,
  input  logic        [dcr_pkg::RAD_W-1:0]    second_radius_i,
  input  logic        [dcr_pkg::MASS_W-1:0]   second_mass_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic        [dcr_pkg::REST_W-1:0]   cfg_data_i,
  output logic                                done_o,
  output logic                                collided_o,
  output logic signed [dcr_pkg::VEL_W-1:0]    new_first_vel_x_o,
  output logic signed [dcr_pkg::VEL_W-1:0]    new_first_vel_y_o,
  output logic signed [dcr_pkg::VEL_W-1:0]    new_second_vel_x_o,
  output logic signed [dcr_pkg::VEL_W-1:0]    new_second_vel_y_o
);

  localparam int DIFF_W = dcr_pkg::DIFF_W;
  localparam int SQ_W   = dcr_pkg::SQ_W;
  localparam int D2_W   = dcr_pkg::D2_W;
  localparam int P_W    = dcr_pkg::P_W;
  localparam int AX_W   = dcr_pkg::AXIS_W;
  localparam int PL_W   = dcr_pkg::PL_W;
  localparam int PH_W   = dcr_pkg::PH_W;
  localparam int PP_W   = dcr_pkg::PP_W;
  localparam int NUM_W  = dcr_pkg::DIV_NUM_W;
  localparam int DEN_W  = dcr_pkg::DIV_DEN_W;
  localparam int QUO_W  = dcr_pkg::DIV_QUO_W;
  localparam int LAT    = dcr_pkg::DIV_LAT;
  localparam int FW     = dcr_pkg::FACT_W;
  localparam int PR_W   = dcr_pkg::PROD_W;
  localparam int TR_W   = dcr_pkg::TRIM_W;
  localparam int ACC_W  = dcr_pkg::ACC_W;
  localparam int VW     = dcr_pkg::VEL_W;
  localparam int MSUM_W = dcr_pkg::MASS_W + 1;

  // Clamp a wide signed sum to the velocity range
  function automatic logic signed [VW-1:0] sat(input logic [ACC_W-1:0] a);
    logic over;
    over = !((&a[ACC_W-1:VW-1]) || !(|a[ACC_W-1:VW-1]));
    if (!over) begin
      sat = a[VW-1:0];
    end else if (a[ACC_W-1]) begin
      sat = {1'b1, {(VW-1){1'b0}}};
    end else begin
      sat = {1'b0, {(VW-1){1'b1}}};
    end
  endfunction

  // Restitution register
  logic [dcr_pkg::REST_W-1:0] rest_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_q <= dcr_pkg::REST_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      rest_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  // Stage 1: differences
  logic                     s1_v_q;
  logic signed [DIFF_W-1:0] s1_dx_q, s1_dy_q, s1_dvx_q, s1_dvy_q;
  logic [dcr_pkg::RS_W-1:0] s1_rs_q;
  logic [dcr_pkg::MASS_W-1:0] s1_m1_q, s1_m2_q;
  dcr_pkg::vel_t            s1_vel_q;

  always_ff @(posedge clk_i) begin
    s1_dx_q      <= DIFF_W'(second_x_i) - DIFF_W'(first_x_i);
    s1_dy_q      <= DIFF_W'(second_y_i) - DIFF_W'(first_y_i);
    s1_dvx_q     <= DIFF_W'(first_vel_x_i) - DIFF_W'(second_vel_x_i);
    s1_dvy_q     <= DIFF_W'(first_vel_y_i) - DIFF_W'(second_vel_y_i);
    s1_rs_q      <= dcr_pkg::RS_W'(first_radius_i) + dcr_pkg::RS_W'(second_radius_i);
    s1_m1_q      <= first_mass_i;
    s1_m2_q      <= second_mass_i;
    s1_vel_q.vx1 <= first_vel_x_i;
    s1_vel_q.vy1 <= first_vel_y_i;
    s1_vel_q.vx2 <= second_vel_x_i;
    s1_vel_q.vy2 <= second_vel_y_i;
  end

  // Stage 2: squares, products and mass numerators
  logic [DIFF_W-1:0]        ax_d, ay_d;
  logic                     s2_v_q;
  logic [SQ_W-1:0]          s2_sqx_q, s2_sqy_q;
  logic [dcr_pkg::RSQ_W-1:0] s2_rsq_q;
  logic signed [SQ_W-1:0]   s2_pdx_q, s2_pdy_q;
  logic [dcr_pkg::NM_W-1:0] s2_nm1_q, s2_nm2_q;
  logic [MSUM_W-1:0]        s2_msum_q;
  logic                     s2_dvz_q, s2_negx_q, s2_negy_q;
  logic [AX_W-1:0]          s2_ax_q, s2_ay_q;
  dcr_pkg::vel_t            s2_vel_q;
  logic [dcr_pkg::REST_W:0] one_e;

  always_comb begin
    ax_d  = s1_dx_q[DIFF_W-1] ? DIFF_W'(-s1_dx_q) : DIFF_W'(s1_dx_q);
    ay_d  = s1_dy_q[DIFF_W-1] ? DIFF_W'(-s1_dy_q) : DIFF_W'(s1_dy_q);
    one_e = (dcr_pkg::REST_W+1)'(rest_q) + (dcr_pkg::REST_W+1)'(1 << dcr_pkg::REST_FRAC);
  end

  always_ff @(posedge clk_i) begin
    s2_sqx_q  <= SQ_W'(ax_d) * SQ_W'(ax_d);
    s2_sqy_q  <= SQ_W'(ay_d) * SQ_W'(ay_d);
    s2_rsq_q  <= dcr_pkg::RSQ_W'(s1_rs_q) * dcr_pkg::RSQ_W'(s1_rs_q);
    s2_pdx_q  <= SQ_W'(s1_dx_q) * SQ_W'(s1_dvx_q);
    s2_pdy_q  <= SQ_W'(s1_dy_q) * SQ_W'(s1_dvy_q);
    s2_nm1_q  <= dcr_pkg::NM_W'(s1_m2_q) * dcr_pkg::NM_W'(one_e);
    s2_nm2_q  <= dcr_pkg::NM_W'(s1_m1_q) * dcr_pkg::NM_W'(one_e);
    s2_msum_q <= MSUM_W'(s1_m1_q) + MSUM_W'(s1_m2_q);
    s2_dvz_q  <= (s1_dvx_q == '0) && (s1_dvy_q == '0);
    s2_negx_q <= s1_dx_q[DIFF_W-1];
    s2_negy_q <= s1_dy_q[DIFF_W-1];
    s2_ax_q   <= ax_d[AX_W-1:0];
    s2_ay_q   <= ay_d[AX_W-1:0];
    s2_vel_q  <= s1_vel_q;
  end

  // Stage 3: squared distance, closing product, mass divide operands
  logic                     s3_v_q;
  logic [D2_W-1:0]          s3_d2_q;
  logic signed [P_W-1:0]    s3_p_q;
  logic [dcr_pkg::RSQ_W-1:0] s3_rsq_q;
  logic [NUM_W-1:0]         s3_mnum1_q, s3_mnum2_q;
  logic [DEN_W-1:0]         s3_mden_q;
  logic                     s3_mz_q, s3_dvz_q, s3_negx_q, s3_negy_q;
  logic [AX_W-1:0]          s3_ax_q, s3_ay_q;
  dcr_pkg::vel_t            s3_vel_q;

  always_ff @(posedge clk_i) begin
    s3_d2_q    <= D2_W'(s2_sqx_q) + D2_W'(s2_sqy_q);
    s3_p_q     <= P_W'(s2_pdx_q) + P_W'(s2_pdy_q);
    s3_rsq_q   <= s2_rsq_q;
    s3_mnum1_q <= (NUM_W'(s2_nm1_q) << dcr_pkg::FRAC_BITS)
                + (NUM_W'(s2_msum_q) << (dcr_pkg::REST_FRAC - 1));
    s3_mnum2_q <= (NUM_W'(s2_nm2_q) << dcr_pkg::FRAC_BITS)
                + (NUM_W'(s2_msum_q) << (dcr_pkg::REST_FRAC - 1));
    s3_mden_q  <= DEN_W'(s2_msum_q) << dcr_pkg::REST_FRAC;
    s3_mz_q    <= (s2_msum_q == '0);
    s3_dvz_q   <= s2_dvz_q;
    s3_negx_q  <= s2_negx_q;
    s3_negy_q  <= s2_negy_q;
    s3_ax_q    <= s2_ax_q;
    s3_ay_q    <= s2_ay_q;
    s3_vel_q   <= s2_vel_q;
  end

  // Stage 4: collision decision and partial products of P * |da|
  logic                     s4_v_q;
  logic                     s4_hit_q, s4_negx_q, s4_negy_q;
  logic [PL_W+AX_W-1:0]     s4_plx_q, s4_ply_q;
  logic [PH_W+AX_W-1:0]     s4_phx_q, s4_phy_q;
  logic [D2_W-1:0]          s4_d2_q;
  logic [NUM_W-1:0]         s4_mnum1_q, s4_mnum2_q;
  logic [DEN_W-1:0]         s4_mden_q;
  dcr_pkg::vel_t            s4_vel_q;
  logic [PL_W-1:0]          p_lo;
  logic [PH_W-1:0]          p_hi;

  always_comb begin
    p_lo = s3_p_q[PL_W-1:0];
    p_hi = s3_p_q[PL_W+PH_W-1:PL_W];
  end

  always_ff @(posedge clk_i) begin
    s4_hit_q   <= !s3_dvz_q && (s3_d2_q != '0) && (s3_d2_q <= D2_W'(s3_rsq_q))
                && !s3_p_q[P_W-1] && (s3_p_q != '0) && !s3_mz_q;
    s4_plx_q   <= (PL_W+AX_W)'(p_lo) * (PL_W+AX_W)'(s3_ax_q);
    s4_ply_q   <= (PL_W+AX_W)'(p_lo) * (PL_W+AX_W)'(s3_ay_q);
    s4_phx_q   <= (PH_W+AX_W)'(p_hi) * (PH_W+AX_W)'(s3_ax_q);
    s4_phy_q   <= (PH_W+AX_W)'(p_hi) * (PH_W+AX_W)'(s3_ay_q);
    s4_d2_q    <= s3_d2_q;
    s4_mnum1_q <= s3_mnum1_q;
    s4_mnum2_q <= s3_mnum2_q;
    s4_mden_q  <= s3_mden_q;
    s4_negx_q  <= s3_negx_q;
    s4_negy_q  <= s3_negy_q;
    s4_vel_q   <= s3_vel_q;
  end

  // Stage 5: combine partial products
  logic                     s5_v_q;
  logic [PP_W-1:0]          s5_prodx_q, s5_prody_q;
  logic [D2_W-1:0]          s5_d2_q;
  logic [NUM_W-1:0]         s5_mnum1_q, s5_mnum2_q;
  logic [DEN_W-1:0]         s5_mden_q;
  dcr_pkg::side_t           s5_side_q;

  always_ff @(posedge clk_i) begin
    s5_prodx_q     <= (PP_W'(s4_phx_q) << PL_W) + PP_W'(s4_plx_q);
    s5_prody_q     <= (PP_W'(s4_phy_q) << PL_W) + PP_W'(s4_ply_q);
    s5_d2_q        <= s4_d2_q;
    s5_mnum1_q     <= s4_mnum1_q;
    s5_mnum2_q     <= s4_mnum2_q;
    s5_mden_q      <= s4_mden_q;
    s5_side_q.hit  <= s4_hit_q;
    s5_side_q.negx <= s4_negx_q;
    s5_side_q.negy <= s4_negy_q;
    s5_side_q.vel  <= s4_vel_q;
  end

  // Rounded quotients: q = (2*P*|da| + d2) / (2*d2), f = mass factors
  logic [NUM_W-1:0] numx, numy;
  logic [DEN_W-1:0] den_ax;
  logic [QUO_W-1:0] qx, qy, f1q, f2q;

  always_comb begin
    numx   = (NUM_W'(s5_prodx_q) << 1) + NUM_W'(s5_d2_q);
    numy   = (NUM_W'(s5_prody_q) << 1) + NUM_W'(s5_d2_q);
    den_ax = DEN_W'({s5_d2_q, 1'b0});
  end

  dcr_div u_div_x  (.clk_i(clk_i), .num_i(numx),       .den_i(den_ax),    .quo_o(qx));
  dcr_div u_div_y  (.clk_i(clk_i), .num_i(numy),       .den_i(den_ax),    .quo_o(qy));
  dcr_div u_div_f1 (.clk_i(clk_i), .num_i(s5_mnum1_q), .den_i(s5_mden_q), .quo_o(f1q));
  dcr_div u_div_f2 (.clk_i(clk_i), .num_i(s5_mnum2_q), .den_i(s5_mden_q), .quo_o(f2q));

  // Carry the echo data alongside the dividers
  dcr_pkg::side_t side_q [LAT];
  logic [LAT-1:0] sv_q;

  always_ff @(posedge clk_i) begin
    side_q[0] <= s5_side_q;
    for (int k = 1; k < LAT; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  // Scale by the mass factors
  logic                 m_v_q;
  logic [PR_W-1:0]      m_p1x_q, m_p2x_q, m_p1y_q, m_p2y_q;
  dcr_pkg::side_t       m_side_q;
  logic [FW-1:0]        f1, f2;

  always_comb begin
    f1 = f1q[FW-1:0];
    f2 = f2q[FW-1:0];
  end

  always_ff @(posedge clk_i) begin
    m_p1x_q  <= PR_W'(qx) * PR_W'(f1);
    m_p2x_q  <= PR_W'(qx) * PR_W'(f2);
    m_p1y_q  <= PR_W'(qy) * PR_W'(f1);
    m_p2y_q  <= PR_W'(qy) * PR_W'(f2);
    m_side_q <= side_q[LAT-1];
  end

  // Round away the fraction
  localparam logic [PR_W:0] HALF = (PR_W+1)'(1) << (dcr_pkg::FRAC_BITS - 1);
  logic                 r_v_q;
  logic [TR_W-1:0]      r_t1x_q, r_t2x_q, r_t1y_q, r_t2y_q;
  dcr_pkg::side_t       r_side_q;

  always_ff @(posedge clk_i) begin
    r_t1x_q  <= TR_W'(((PR_W+1)'(m_p1x_q) + HALF) >> dcr_pkg::FRAC_BITS);
    r_t2x_q  <= TR_W'(((PR_W+1)'(m_p2x_q) + HALF) >> dcr_pkg::FRAC_BITS);
    r_t1y_q  <= TR_W'(((PR_W+1)'(m_p1y_q) + HALF) >> dcr_pkg::FRAC_BITS);
    r_t2y_q  <= TR_W'(((PR_W+1)'(m_p2y_q) + HALF) >> dcr_pkg::FRAC_BITS);
    r_side_q <= m_side_q;
  end

  // Apply the response along the normal and saturate
  logic [ACC_W-1:0] a1x, a1y, a2x, a2y;
  logic [ACC_W-1:0] v1x, v1y, v2x, v2y;
  logic [ACC_W-1:0] t1x, t1y, t2x, t2y;
  logic             o_v_q, o_col_q;
  dcr_pkg::vel_t    o_vel_q;

  always_comb begin
    v1x = ACC_W'(r_side_q.vel.vx1);
    v1y = ACC_W'(r_side_q.vel.vy1);
    v2x = ACC_W'(r_side_q.vel.vx2);
    v2y = ACC_W'(r_side_q.vel.vy2);
    t1x = ACC_W'(r_t1x_q);
    t2x = ACC_W'(r_t2x_q);
    t1y = ACC_W'(r_t1y_q);
    t2y = ACC_W'(r_t2y_q);
    a1x = r_side_q.negx ? v1x + t1x : v1x - t1x;
    a2x = r_side_q.negx ? v2x - t2x : v2x + t2x;
    a1y = r_side_q.negy ? v1y + t1y : v1y - t1y;
    a2y = r_side_q.negy ? v2y - t2y : v2y + t2y;
  end

  always_ff @(posedge clk_i) begin
    o_col_q <= r_side_q.hit;
    if (r_side_q.hit) begin
      o_vel_q.vx1 <= sat(a1x);
      o_vel_q.vy1 <= sat(a1y);
      o_vel_q.vx2 <= sat(a2x);
      o_vel_q.vy2 <= sat(a2y);
    end else begin
      o_vel_q <= r_side_q.vel;
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      sv_q   <= '0;
      m_v_q  <= 1'b0;
      r_v_q  <= 1'b0;
      o_v_q  <= 1'b0;
    end else begin
      s1_v_q <= start && !busy;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
      sv_q   <= {sv_q[LAT-2:0], s5_v_q};
      m_v_q  <= sv_q[LAT-1];
      r_v_q  <= m_v_q;
      o_v_q  <= r_v_q;
    end
  end

  assign done_o             = o_v_q;
  assign collided_o         = o_col_q;
  assign new_first_vel_x_o  = o_vel_q.vx1;
  assign new_first_vel_y_o  = o_vel_q.vy1;
  assign new_second_vel_x_o = o_vel_q.vx2;
  assign new_second_vel_y_o = o_vel_q.vy2;

endmodule

// ----- design/dcr_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Depends on dcr_pkg for its widths; quo_o is taken from the last stage register.
module dcr_div (
  input  logic                           clk_i,
  input  logic [dcr_pkg::DIV_NUM_W-1:0]  num_i,
  input  logic [dcr_pkg::DIV_DEN_W-1:0]  den_i,
  output logic [dcr_pkg::DIV_QUO_W-1:0]  quo_o
);

  localparam int QW = dcr_pkg::DIV_QUO_W;
  localparam int DW = dcr_pkg::DIV_DEN_W;

  logic [DW-1:0] rem_q [QW+1];
  logic [QW-1:0] low_q [QW+1];
  logic [DW-1:0] den_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];

  logic [DW:0]   trial [QW];
  logic [DW:0]   diff  [QW];
  logic          take  [QW];

  // Trial subtract for every stage
  always_comb begin
    for (int k = 0; k < QW; k++) begin
      trial[k] = {rem_q[k], low_q[k][QW-1]};
      diff[k]  = trial[k] - {1'b0, den_q[k]};
      take[k]  = (trial[k] >= {1'b0, den_q[k]});
    end
  end

  // Load the partial remainder, then advance one bit per stage
  always_ff @(posedge clk_i) begin
    rem_q[0] <= num_i[dcr_pkg::DIV_NUM_W-1:QW];
    low_q[0] <= num_i[QW-1:0];
    den_q[0] <= den_i;
    quo_q[0] <= '0;
    for (int k = 0; k < QW; k++) begin
      rem_q[k+1] <= take[k] ? diff[k][DW-1:0] : trial[k][DW-1:0];
      low_q[k+1] <= {low_q[k][QW-2:0], 1'b0};
      den_q[k+1] <= den_q[k];
      quo_q[k+1] <= {quo_q[k][QW-2:0], take[k]};
    end
  end

  assign quo_o = quo_q[QW];

endmodule

// ----- bench/disc_collision_response_test.sv -----
// Bench for disc_collision_response: sends disc pairs, predicts each response
// from the pair and the restitution setting, and checks every strobed result.
// Depends on dcr_pkg and the disc_collision_response RTL.
module disc_collision_response_test;

  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 600000;

  typedef struct {
    logic signed [dcr_pkg::VEL_W-1:0] x1, y1, vx1, vy1;
    logic [dcr_pkg::RAD_W-1:0]        r1;
    logic [dcr_pkg::MASS_W-1:0]       m1;
    logic signed [dcr_pkg::VEL_W-1:0] x2, y2, vx2, vy2;
    logic [dcr_pkg::RAD_W-1:0]        r2;
    logic [dcr_pkg::MASS_W-1:0]       m2;
  } disc_pair_t;

  typedef struct {
    logic collided;
    dcr_pkg::vel_t vel;
  } response_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [dcr_pkg::VEL_W-1:0] first_x_i = '0, first_y_i = '0;
  logic signed [dcr_pkg::VEL_W-1:0] first_vel_x_i = '0, first_vel_y_i = '0;
  logic [dcr_pkg::RAD_W-1:0] first_radius_i = '0, second_radius_i = '0;
  logic [dcr_pkg::MASS_W-1:0] first_mass_i = '0, second_mass_i = '0;
  logic signed [dcr_pkg::VEL_W-1:0] second_x_i = '0, second_y_i = '0;
  logic signed [dcr_pkg::VEL_W-1:0] second_vel_x_i = '0, second_vel_y_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [dcr_pkg::REST_W-1:0] cfg_data_i = '0;
  logic done_o, collided_o;
  logic signed [dcr_pkg::VEL_W-1:0] new_first_vel_x_o, new_first_vel_y_o;
  logic signed [dcr_pkg::VEL_W-1:0] new_second_vel_x_o, new_second_vel_y_o;

  response_t pending_responses[$];
  logic [dcr_pkg::REST_W-1:0] restitution_copy = dcr_pkg::REST_RESET;
  int error_count = 0;
  int cycle_count = 0;
  int idle_mode = 0;

  disc_collision_response DUT (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic signed [dcr_pkg::VEL_W-1:0] saturate(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[dcr_pkg::VEL_W-1:0];
  endfunction

  // Normal response along one axis: rounded P*|da|/d2, scaled by a mass factor
  function automatic longint axis_impulse(logic signed [135:0] p, longint da,
                                          logic signed [135:0] d2, longint factor);
    logic signed [135:0] num;
    logic signed [135:0] quo;
    longint q;
    num = 2 * p * (da < 0 ? -da : da) + d2;
    quo = num / (2 * d2);
    q = quo[63:0];
    return (q * factor + (64'sd1 <<< (dcr_pkg::FRAC_BITS - 1))) >>> dcr_pkg::FRAC_BITS;
  endfunction

  function automatic response_t collision_outcome(disc_pair_t d,
                                                  logic [dcr_pkg::REST_W-1:0] e);
    response_t r;
    longint dx, dy, dvx, dvy, msum, den, f1, f2, t1x, t1y, t2x, t2y, sgx, sgy;
    logic signed [135:0] w_dx, w_dy, w_dvx, w_dvy, d2, p, rs;
    logic hit;
    dx = longint'(d.x2) - longint'(d.x1);
    dy = longint'(d.y2) - longint'(d.y1);
    dvx = longint'(d.vx1) - longint'(d.vx2);
    dvy = longint'(d.vy1) - longint'(d.vy2);
    w_dx = 136'(dx); w_dy = 136'(dy); w_dvx = 136'(dvx); w_dvy = 136'(dvy);
    d2 = w_dx * w_dx + w_dy * w_dy;
    p = w_dx * w_dvx + w_dy * w_dvy;
    rs = $signed({105'd0, d.r1}) + $signed({105'd0, d.r2});
    msum = longint'(d.m1) + longint'(d.m2);
    r.collided = 1'b0;
    r.vel = '{vx1: d.vx1, vy1: d.vy1, vx2: d.vx2, vy2: d.vy2};
    hit = !(dvx == 0 && dvy == 0) && d2 != 0 && !(d2 > rs * rs) && p > 0 && msum != 0;
    if (hit) begin
      den = msum * 65536;
      f1 = (((longint'(d.m2) * (65536 + longint'(e))) <<< dcr_pkg::FRAC_BITS) + den / 2)
           / den;
      f2 = (((longint'(d.m1) * (65536 + longint'(e))) <<< dcr_pkg::FRAC_BITS) + den / 2)
           / den;
      t1x = axis_impulse(p, dx, d2, f1);
      t2x = axis_impulse(p, dx, d2, f2);
      t1y = axis_impulse(p, dy, d2, f1);
      t2y = axis_impulse(p, dy, d2, f2);
      sgx = dx > 0 ? 1 : (dx < 0 ? -1 : 0);
      sgy = dy > 0 ? 1 : (dy < 0 ? -1 : 0);
      r.collided = 1'b1;
      r.vel.vx1 = saturate(longint'(d.vx1) - sgx * t1x);
      r.vel.vy1 = saturate(longint'(d.vy1) - sgy * t1y);
      r.vel.vx2 = saturate(longint'(d.vx2) + sgx * t2x);
      r.vel.vy2 = saturate(longint'(d.vy2) + sgy * t2y);
    end
    return r;
  endfunction

  // Compare each strobed result with the oldest prediction
  always @(posedge clk_i) begin
    response_t want;
    if (rst_ni && done_o) begin
      if (pending_responses.size() == 0) begin
        $display("%0t: unexpected result collided=%0b", $time, collided_o);
        error_count++;
      end else begin
        want = pending_responses.pop_front();
        if (collided_o !== want.collided) begin
          $display("%0t: collided expected %0b actual %0b", $time, want.collided, collided_o);
          error_count++;
        end
        if (new_first_vel_x_o !== want.vel.vx1) begin
          $display("%0t: new_first_vel_x expected %0d actual %0d", $time,
                   want.vel.vx1, new_first_vel_x_o);
          error_count++;
        end
        if (new_first_vel_y_o !== want.vel.vy1) begin
          $display("%0t: new_first_vel_y expected %0d actual %0d", $time,
                   want.vel.vy1, new_first_vel_y_o);
          error_count++;
        end
        if (new_second_vel_x_o !== want.vel.vx2) begin
          $display("%0t: new_second_vel_x expected %0d actual %0d", $time,
                   want.vel.vx2, new_second_vel_x_o);
          error_count++;
        end
        if (new_second_vel_y_o !== want.vel.vy2) begin
          $display("%0t: new_second_vel_y expected %0d actual %0d", $time,
                   want.vel.vy2, new_second_vel_y_o);
          error_count++;
        end
      end
    end
  end

  // Idle mode 0 sends back to back; otherwise mostly short gaps, a few long
  function automatic int random_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (idle_mode == 0) return 0;
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Drive one request and record its predicted response on acceptance
  task automatic send_pair(disc_pair_t d);
    int gap;
    start <= 1'b1;
    first_x_i <= d.x1; first_y_i <= d.y1;
    first_vel_x_i <= d.vx1; first_vel_y_i <= d.vy1;
    first_radius_i <= d.r1; first_mass_i <= d.m1;
    second_x_i <= d.x2; second_y_i <= d.y2;
    second_vel_x_i <= d.vx2; second_vel_y_i <= d.vy2;
    second_radius_i <= d.r2; second_mass_i <= d.m2;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_responses.push_back(collision_outcome(d, restitution_copy));
    gap = random_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Write restitution once the pipeline has drained
  task automatic set_restitution(logic [dcr_pkg::REST_W-1:0] value);
    start <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    restitution_copy = value;
  endtask

  function automatic disc_pair_t make_pair(int x1, int y1, int vx1, int vy1, int r1, int m1,
                                           int x2, int y2, int vx2, int vy2, int r2, int m2);
    disc_pair_t d;
    d.x1 = x1; d.y1 = y1; d.vx1 = vx1; d.vy1 = vy1;
    d.r1 = dcr_pkg::RAD_W'(r1); d.m1 = dcr_pkg::MASS_W'(m1);
    d.x2 = x2; d.y2 = y2; d.vx2 = vx2; d.vy2 = vy2;
    d.r2 = dcr_pkg::RAD_W'(r2); d.m2 = dcr_pkg::MASS_W'(m2);
    return d;
  endfunction

  function automatic logic signed [dcr_pkg::VEL_W-1:0] random_signed();
    return $signed($urandom) >>> $urandom_range(0, 31);
  endfunction

  // Pair placed so the discs usually touch, with random approach
  function automatic disc_pair_t random_close_pair();
    disc_pair_t d;
    logic signed [dcr_pkg::VEL_W-1:0] dx, dy;
    d.x1 = $urandom; d.y1 = $urandom;
    dx = $signed($urandom) >>> $urandom_range(8, 31);
    dy = $signed($urandom) >>> $urandom_range(8, 31);
    if ($urandom_range(0, 9) == 0) dy = 0;
    else if ($urandom_range(0, 9) == 0) dx = 0;
    d.x2 = d.x1 + dx; d.y2 = d.y1 + dy;
    d.r1 = dcr_pkg::RAD_W'(((dx < 0 ? -longint'(dx) : longint'(dx))
                           + (dy < 0 ? -longint'(dy) : longint'(dy)))
                          >> $urandom_range(1, 2));
    d.r2 = dcr_pkg::RAD_W'(32'(d.r1) + ($urandom >> $urandom_range(8, 31)));
    d.vx1 = random_signed(); d.vy1 = random_signed();
    d.vx2 = random_signed(); d.vy2 = random_signed();
    d.m1 = $urandom_range(0, 19) == 0 ? '0
           : dcr_pkg::MASS_W'($urandom >> $urandom_range(0, 15));
    d.m2 = $urandom_range(0, 19) == 0 ? '0
           : dcr_pkg::MASS_W'($urandom >> $urandom_range(0, 15));
    return d;
  endfunction

  function automatic disc_pair_t random_noise_pair();
    disc_pair_t d;
    d = make_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    return d;
  endfunction

  // Extremes and each no-collision case named by the spec
  task automatic test_directed();
    int one;
    one = 65536;
    idle_mode = 1;
    // equal velocities
    send_pair(make_pair(0, 0, one, one, one, 1, one, 0, one, one, one, 1));
    // too far apart, then exactly touching
    send_pair(make_pair(0, 0, one, 0, one, 1, 3 * one, 0, 0, 0, one, 1));
    send_pair(make_pair(0, 0, one, 0, one, 1, 2 * one, 0, 0, 0, one, 1));
    // coincident centres
    send_pair(make_pair(5, 5, one, 0, one, 1, 5, 5, 0, 0, one, 1));
    // separating and resting
    send_pair(make_pair(0, 0, -one, 0, one, 1, one, 0, 0, 0, one, 1));
    send_pair(make_pair(0, 0, 0, one, one, 1, one, 0, 0, 0, one, 1));
    // both masses zero, one mass zero
    send_pair(make_pair(0, 0, one, 0, one, 0, one, 0, 0, 0, one, 0));
    send_pair(make_pair(0, 0, one, 0, one, 0, one, 0, 0, 0, one, 5));
    send_pair(make_pair(0, 0, one, 0, one, 7, one, 0, 0, 0, one, 0));
    // head-on, diagonal and oblique hits
    send_pair(make_pair(0, 0, one, 0, one, 1, one, 0, -one, 0, one, 1));
    send_pair(make_pair(0, 0, one, one, one, 3, one, one, 0, 0, one, 5));
    send_pair(make_pair(0, 0, 3 * one, -one, 2 * one, 65535, one, 2 * one, 0, one, one, 1));
    // saturation at the velocity extremes
    send_pair(make_pair(0, 0, 32'sh7fffffff, 32'sh7fffffff, 32'h7fffffff, 1,
                        one, one, 32'sh80000000, 32'sh80000000, 32'h7fffffff, 65535));
    send_pair(make_pair(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 0, 32'h7fffffff,
                        65535, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 0,
                        32'h7fffffff, 65535));
    send_pair(make_pair(32'sh7fffffff, 0, 0, 0, 32'h7fffffff, 1,
                        32'sh80000000, 0, 0, 0, 32'h7fffffff, 1));
    send_pair(make_pair(-1, -1, -1, -1, 0, 65535, -1, -1, -1, -1, 0, 65535));
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) idle_mode = $urandom_range(0, 2);
      if ($urandom_range(0, 9) < 8) send_pair(random_close_pair());
      else send_pair(random_noise_pair());
    end
  endtask

  task automatic test_restitution_settings();
    logic [dcr_pkg::REST_W-1:0] settings[5];
    settings = '{17'd0, 17'd65536, 17'd32768, 17'h1ffff, 17'd65535};
    foreach (settings[k]) begin
      set_restitution(settings[k]);
      test_random(200);
    end
    set_restitution(dcr_pkg::REST_W'($urandom_range(0, 65536)));
    test_random(200);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(650);
    set_restitution(17'd0);
    test_directed();
    test_restitution_settings();
    start <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
